@@ rtl/cfe_pkg.sv @@
package cfe_pkg;

    localparam int NUMBER_BITS = 31;

    // trial divisor p never exceeds sqrt(2^NUMBER_BITS) + 1
    localparam int P_W = (NUMBER_BITS + 1) / 2 + 1;

    // running p*p, one past the largest value that can still compare low
    localparam int SQ_W = NUMBER_BITS + 2;

    // bit counter of the serial divider
    localparam int CNT_W = (NUMBER_BITS > 1) ? $clog2(NUMBER_BITS) : 1;

    typedef logic [NUMBER_BITS-1:0] t_word;
    typedef logic [P_W-1:0]         t_prime;
    typedef logic [SQ_W-1:0]        t_square;

endpackage

@@ rtl/cfe_div.sv @@
module cfe_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  cfe_pkg::t_word i_dividend,
    input  cfe_pkg::t_word i_divisor,
    output logic          o_done,
    output cfe_pkg::t_word o_quot,
    output cfe_pkg::t_word o_rem
);

    localparam int W = cfe_pkg::NUMBER_BITS;

    logic                      r_busy;
    logic                      r_done;
    logic [cfe_pkg::CNT_W-1:0] r_cnt;
    cfe_pkg::t_word            r_num;
    cfe_pkg::t_word            r_rem;
    cfe_pkg::t_word            r_den;

    logic [W:0] trial;
    logic [W:0] diff;
    logic       qbit;

    // one quotient bit per cycle, restoring form
    assign trial = {r_rem, r_num[W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign qbit  = ~diff[W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= cfe_pkg::CNT_W'(W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[W-2:0], qbit};
            r_rem <= qbit ? diff[W-1:0] : trial[W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
    assign o_rem  = r_rem;

endmodule

@@ rtl/carmichael_fermat_all_bases_test_top.sv @@
// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_stall    i_number  (31 bits)
// result    out        o_out_valid / i_out_stall  o_passes  (1 bit)
//
// n below 3 goes straight to the result state. Otherwise n is factored by trial
// division through one bit-serial divider; each trial divisor p costs one compare
// state and one to three divisions.
// Reset is synchronous and clears the sequencer and the result valid only.
// A finished result waits in the output register while the next n is taken.
module carmichael_fermat_all_bases_test_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [cfe_pkg::NUMBER_BITS-1:0]    i_number,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_passes
);

    localparam int W = cfe_pkg::NUMBER_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_D1   = 3'd2;
    localparam logic [2:0] S_D2   = 3'd3;
    localparam logic [2:0] S_DM   = 3'd4;
    localparam logic [2:0] S_DT   = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]       r_state, n_state;
    cfe_pkg::t_word   r_m, n_m;
    cfe_pkg::t_word   r_rest, n_rest;
    cfe_pkg::t_prime  r_p, n_p;
    cfe_pkg::t_square r_sq, n_sq;
    logic             r_pass, n_pass;
    logic             r_out_valid, n_out_valid;
    logic             r_passes, n_passes;

    logic             div_start;
    cfe_pkg::t_word   div_dividend;
    cfe_pkg::t_word   div_divisor;
    logic             div_done;
    cfe_pkg::t_word   div_quot;
    cfe_pkg::t_word   div_rem;

    logic             in_xfer;
    logic             rem_zero;
    cfe_pkg::t_word   p_word;

    cfe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign rem_zero = (div_rem == '0);
    assign p_word   = W'(r_p);

    always_comb begin
        n_state      = r_state;
        n_m          = r_m;
        n_rest       = r_rest;
        n_p          = r_p;
        n_sq         = r_sq;
        n_pass       = r_pass;
        n_out_valid  = r_out_valid && i_out_stall;
        n_passes     = r_passes;
        div_start    = 1'b0;
        div_dividend = r_rest;
        div_divisor  = p_word;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_m    = i_number - 1'b1;
                    n_rest = i_number;
                    n_p    = cfe_pkg::P_W'(2);
                    n_sq   = cfe_pkg::SQ_W'(4);
                    n_pass = 1'b1;
                    n_state = (i_number < W'(3)) ? S_FIN : S_CHK;
                end
            end
            S_CHK: begin
                if (r_sq <= cfe_pkg::SQ_W'(r_rest)) begin
                    div_start = 1'b1;
                    n_state   = S_D1;
                end else if (r_rest > W'(1)) begin
                    // leftover prime factor: (rest - 1) must divide n - 1
                    div_start    = 1'b1;
                    div_dividend = r_m;
                    div_divisor  = r_rest - 1'b1;
                    n_state      = S_DT;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_D1: begin
                if (div_done) begin
                    if (rem_zero) begin
                        // p divides n: drop it once, then test for a square factor
                        n_rest       = div_quot;
                        div_start    = 1'b1;
                        div_dividend = div_quot;
                        n_state      = S_D2;
                    end else begin
                        n_p     = r_p + 1'b1;
                        n_sq    = r_sq + cfe_pkg::SQ_W'({r_p, 1'b1});
                        n_state = S_CHK;
                    end
                end
            end
            S_D2: begin
                if (div_done) begin
                    if (rem_zero) begin
                        n_pass  = 1'b0;
                        n_state = S_FIN;
                    end else begin
                        div_start    = 1'b1;
                        div_dividend = r_m;
                        div_divisor  = p_word - 1'b1;
                        n_state      = S_DM;
                    end
                end
            end
            S_DM: begin
                if (div_done) begin
                    if (!rem_zero) begin
                        n_pass  = 1'b0;
                        n_state = S_FIN;
                    end else begin
                        n_p     = r_p + 1'b1;
                        n_sq    = r_sq + cfe_pkg::SQ_W'({r_p, 1'b1});
                        n_state = S_CHK;
                    end
                end
            end
            S_DT: begin
                if (div_done) begin
                    n_pass  = r_pass && rem_zero;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // load the result once the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_passes    = r_pass;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m      <= n_m;
        r_rest   <= n_rest;
        r_p      <= n_p;
        r_sq     <= n_sq;
        r_pass   <= n_pass;
        r_passes <= n_passes;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_passes    = r_passes;

endmodule

@@ tb/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_LIMIT = 6_000_000;
    localparam int unsigned DRAIN_CYCLES   = 200;
    localparam int unsigned HOLD_CYCLES    = 3000;
    localparam int unsigned RANDOM_ITEMS   = 80;
    localparam int unsigned TINY_BURST     = 8;

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    cfe_pkg::t_word i_number    = '0;
    logic           i_out_stall = 1'b0;
    logic           o_in_stall;
    logic           o_out_valid;
    logic           o_passes;

    // known Carmichael numbers that fit the field
    int unsigned carmichael_numbers[14] = '{561, 1105, 1729, 2465, 2821, 6601, 8911,
                                            10585, 15841, 29341, 41041, 46657,
                                            52633, 62745};

    cfe_pkg::t_word pending_numbers[$];
    bit             expected_passes[$];
    int unsigned    directed_count;
    int unsigned    numbers_sent;
    int unsigned    results_seen;
    int unsigned    passes_seen;
    int unsigned    error_count;
    int unsigned    idle_cycles;
    int unsigned    send_gap;
    int unsigned    send_calm;
    int unsigned    stall_left;
    int unsigned    stall_calm;
    int unsigned    hold_left;
    bit             hold_done;

    carmichael_fermat_all_bases_test_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_number    (i_number),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_passes    (o_passes)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // n passes iff lambda of every prime-power factor divides n-1
    function automatic bit all_coprime_bases_pass(input cfe_pkg::t_word n);
        longint unsigned rest;
        longint unsigned divisor;
        longint unsigned power;
        longint unsigned lambda_part;
        longint unsigned n_minus_one;
        rest = n;
        if (n < 3) return 1'b1;
        n_minus_one = n - 1;
        for (divisor = 2; divisor * divisor <= rest; divisor++) begin
            if (rest % divisor == 0) begin
                power = 1;
                while (rest % divisor == 0) begin
                    rest  = rest / divisor;
                    power = power * divisor;
                end
                if (divisor == 2 && power >= 8)
                    lambda_part = power / 4;
                else
                    lambda_part = (power / divisor) * (divisor - 1);
                if (lambda_part == 0 || n_minus_one % lambda_part != 0) return 1'b0;
            end
        end
        if (rest > 1 && n_minus_one % (rest - 1) != 0) return 1'b0;
        return 1'b1;
    endfunction

    // mostly short gaps, a few long ones, and calm stretches with none
    task automatic pick_gap(inout int unsigned calm_left, output int unsigned gap);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm_left > 0) begin
            calm_left--;
            gap = 0;
        end else if (roll < 5) begin
            calm_left = $urandom_range(5, 20);
            gap = 0;
        end else if (roll < 55) begin
            gap = 0;
        end else if (roll < 90) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 40);
        end
    endtask

    initial begin
        int unsigned     roll;
        cfe_pkg::t_word  shifted;
        longint unsigned product;
        longint unsigned factor;

        // no bases at all, smallest prime, smallest composites
        pending_numbers.push_back(cfe_pkg::t_word'(0));
        pending_numbers.push_back(cfe_pkg::t_word'(1));
        pending_numbers.push_back(cfe_pkg::t_word'(2));
        pending_numbers.push_back(cfe_pkg::t_word'(3));
        pending_numbers.push_back(cfe_pkg::t_word'(4));
        pending_numbers.push_back(cfe_pkg::t_word'(5));
        pending_numbers.push_back(cfe_pkg::t_word'(6));
        pending_numbers.push_back(cfe_pkg::t_word'(8));
        pending_numbers.push_back(cfe_pkg::t_word'(9));
        pending_numbers.push_back(cfe_pkg::t_word'(25));
        // base-2 pseudoprime that other bases expose
        pending_numbers.push_back(cfe_pkg::t_word'(341));
        pending_numbers.push_back(cfe_pkg::t_word'(561));
        pending_numbers.push_back(cfe_pkg::t_word'(1105));
        pending_numbers.push_back(cfe_pkg::t_word'(1122));
        pending_numbers.push_back(cfe_pkg::t_word'(1729));
        pending_numbers.push_back(cfe_pkg::t_word'(6601));
        pending_numbers.push_back(cfe_pkg::t_word'(41041));
        pending_numbers.push_back(cfe_pkg::t_word'(65521));
        pending_numbers.push_back(cfe_pkg::t_word'(65535));
        pending_numbers.push_back(cfe_pkg::t_word'(32'h4000_0000));
        pending_numbers.push_back(cfe_pkg::t_word'(32'h7fff_fffe));
        // largest field value, a prime: the slowest item of the run
        pending_numbers.push_back(cfe_pkg::t_word'(32'h7fff_ffff));
        directed_count = pending_numbers.size();

        for (int unsigned idx = 0; idx < RANDOM_ITEMS; idx++) begin
            roll = $urandom_range(0, 99);
            if (idx < TINY_BURST) begin
                // fast items so the output hold backs the block up
                pending_numbers.push_back(cfe_pkg::t_word'($urandom_range(0, 63)));
            end else if (roll < 8) begin
                pending_numbers.push_back(cfe_pkg::t_word'($urandom_range(0, 4)));
            end else if (roll < 22) begin
                pending_numbers.push_back(
                    cfe_pkg::t_word'(carmichael_numbers[$urandom_range(0, 13)]));
            end else if (roll < 37) begin
                // large odd number built from small odd factors: cheap to factor
                product = 1;
                factor  = $urandom_range(1, 30) * 2 + 1;
                while (product * factor < 64'h8000_0000) begin
                    product = product * factor;
                    factor  = $urandom_range(1, 30) * 2 + 1;
                end
                pending_numbers.push_back(cfe_pkg::t_word'(product));
            end else if (roll < 47) begin
                shifted = cfe_pkg::t_word'($urandom_range(1, 4095));
                while (!shifted[cfe_pkg::NUMBER_BITS-1]) shifted = shifted << 1;
                pending_numbers.push_back(shifted);
            end else begin
                pending_numbers.push_back(cfe_pkg::t_word'($urandom_range(5, 20000)));
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_numbers.size() > 0 || i_in_valid || expected_passes.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d numbers (%0d directed, up to the largest 31-bit value)",
                 numbers_sent, directed_count);
        $display("%0d results checked, %0d passed every coprime base, output held %0d cycles",
                 results_seen, passes_seen, HOLD_CYCLES);
        if (error_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // driver: hold payload while stalled, advance on transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_passes.push_back(all_coprime_bases_pass(i_number));
                numbers_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_numbers.size() > 0) begin
                    i_number   <= pending_numbers.pop_front();
                    i_in_valid <= 1'b1;
                    pick_gap(send_calm, send_gap);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result transfer, drive the output stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_passes.size() == 0) begin
                    $display("%0t: result %0b with no number outstanding", $time, o_passes);
                    error_count++;
                end else begin
                    bit want;
                    want = expected_passes.pop_front();
                    if (o_passes !== want) begin
                        $display("%0t: passes mismatch: expected %0b actual %0b",
                                 $time, want, o_passes);
                        error_count++;
                    end
                end
                if (o_passes === 1'b1) passes_seen++;
                // hold the output once the directed numbers are done
                if (!hold_done && results_seen == directed_count) begin
                    hold_done = 1'b1;
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                pick_gap(stall_calm, stall_left);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("testbench failed");
            $finish;
        end
    end

endmodule

@@ sim.f @@
rtl/cfe_pkg.sv
rtl/cfe_div.sv
rtl/carmichael_fermat_all_bases_test_top.sv
tb/testbench.sv
